// File: hdl/has_pkg.sv
// Package for the assignment solver: widths, sizes and the sequencer state type.
// Used by has_core and the top level; depends on nothing.
package has_pkg;
  localparam int MAX_SIZE   = 16;
  localparam int COST_WIDTH = 16;
  localparam int IDX_W      = $clog2(MAX_SIZE);
  localparam int ADDR_W     = 2 * IDX_W;
  localparam int DUAL_W     = 32;
  localparam int SZ_W       = IDX_W + 1;
  localparam logic signed [DUAL_W-1:0] SLACK_MAX = {1'b0, {(DUAL_W-1){1'b1}}};

  typedef enum logic [4:0] {
    S_LOAD, S_INIT,
    S_RMIN_RD, S_RMIN_CMP, S_RMIN_WR,
    S_CMIN_RD, S_CMIN_CMP, S_CMIN_WR,
    S_GRD_RD, S_GRD_CMP,
    S_ROW_NEXT, S_TREE_INIT,
    S_SCAN_RD, S_SCAN_CMP, S_PEND,
    S_DELTA, S_DUALS, S_SLK,
    S_PICK, S_AUG,
    S_OUT
  } seq_state_t;
endpackage

// File: hdl/has_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module has_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: hdl/has_core.sv
// Solver sequencer: row/column reduction, greedy match, shortest augmenting trees.
// Depends on has_pkg; cost matrix is read from has_ram through cost_raddr/cost_rdata.
module has_core (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  input  logic [has_pkg::SZ_W-1:0]               n_in,
  output logic [has_pkg::ADDR_W-1:0]             cost_raddr,
  input  logic signed [has_pkg::COST_WIDTH-1:0]  cost_rdata,
  output logic                                   busy,
  output logic                                   res_valid,
  input  logic                                   res_ready,
  output logic [has_pkg::IDX_W-1:0]              res_row,
  output logic [has_pkg::IDX_W-1:0]              res_col,
  output logic                                   res_last
);
  import has_pkg::*;

  seq_state_t state_r, state_nxt;
  logic [SZ_W-1:0] n_r;
  logic [IDX_W-1:0] i_r, j_r, r_r;
  logic [SZ_W-1:0] k_r;
  logic signed [DUAL_W-1:0] acc_r;
  logic signed [DUAL_W-1:0] rdual_r [MAX_SIZE];
  logic signed [DUAL_W-1:0] cdual_r [MAX_SIZE];
  logic signed [DUAL_W-1:0] slack_r [MAX_SIZE];
  logic [IDX_W-1:0] pred_r [MAX_SIZE];
  logic [MAX_SIZE-1:0] cown_v_r, rasg_v_r, lab_r, scol_r, srow_r;
  logic [IDX_W-1:0] cown_r [MAX_SIZE];
  logic [IDX_W-1:0] rasg_r [MAX_SIZE];
  logic [IDX_W:0] guard_r;
  logic [MAX_SIZE-1:0] all_mask, pend;
  logic [IDX_W-1:0] pend_idx;
  logic signed [DUAL_W-1:0] red, cst;
  logic last_i, last_j;

  always_comb begin
    for (int x = 0; x < MAX_SIZE; x++) all_mask[x] = (x < n_r);
  end
  assign pend = lab_r & ~scol_r & all_mask;
  always_comb begin
    pend_idx = '0;
    for (int x = MAX_SIZE - 1; x >= 0; x--) if (pend[x]) pend_idx = IDX_W'(x);
  end

  assign cst    = DUAL_W'(cost_rdata);
  assign last_i = ({1'b0, i_r} == n_r - SZ_W'(1));
  assign last_j = ({1'b0, j_r} == n_r - SZ_W'(1));

  // row being addressed: i (row reduction/greedy), j (column reduction), r (tree scan)
  logic [IDX_W-1:0] ar, ac;
  always_comb begin
    ar = i_r; ac = j_r;
    if (state_r == S_CMIN_RD || state_r == S_CMIN_CMP) begin
      ar = j_r; ac = i_r;
    end else if (state_r == S_SCAN_RD || state_r == S_SCAN_CMP) begin
      ar = r_r;
    end
  end
  assign cost_raddr = {ar, ac};
  assign red = cst - rdual_r[ar] - cdual_r[ac];

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_LOAD:      if (start) state_nxt = S_INIT;
      S_INIT:      state_nxt = S_RMIN_RD;
      S_RMIN_RD:   state_nxt = S_RMIN_CMP;
      S_RMIN_CMP:  state_nxt = last_j ? S_RMIN_WR : S_RMIN_RD;
      S_RMIN_WR:   state_nxt = last_i ? S_CMIN_RD : S_RMIN_RD;
      S_CMIN_RD:   state_nxt = S_CMIN_CMP;
      S_CMIN_CMP:  state_nxt = last_j ? S_CMIN_WR : S_CMIN_RD;
      S_CMIN_WR:   state_nxt = last_i ? S_GRD_RD : S_CMIN_RD;
      S_GRD_RD:    state_nxt = S_GRD_CMP;
      S_GRD_CMP:   state_nxt = (last_i && (last_j || (red == 0 && !cown_v_r[j_r])))
                               ? S_ROW_NEXT : S_GRD_RD;
      S_ROW_NEXT:  if (k_r >= n_r) state_nxt = S_OUT;
                   else if (rasg_v_r[k_r[IDX_W-1:0]]) state_nxt = S_ROW_NEXT;
                   else state_nxt = S_TREE_INIT;
      S_TREE_INIT: state_nxt = S_SCAN_RD;
      S_SCAN_RD:   state_nxt = S_SCAN_CMP;
      S_SCAN_CMP:  state_nxt = last_j ? S_PEND : S_SCAN_RD;
      S_PEND:      state_nxt = (pend == '0) ? S_DELTA : S_PICK;
      S_DELTA:     state_nxt = last_j ? S_DUALS : S_DELTA;
      S_DUALS:     state_nxt = S_SLK;
      S_SLK:       state_nxt = (pend == '0) ? S_ROW_NEXT : S_PICK;
      S_PICK:      if (!cown_v_r[pend_idx]) state_nxt = S_AUG;
                   else if (guard_r >= n_r) state_nxt = S_ROW_NEXT;
                   else state_nxt = S_SCAN_RD;
      S_AUG:       if (pred_r[j_r] == k_r[IDX_W-1:0] || !rasg_v_r[pred_r[j_r]]
                       || guard_r >= n_r)
                     state_nxt = S_ROW_NEXT;
      S_OUT:       if (res_ready && last_i) state_nxt = S_LOAD;
      default:     state_nxt = S_LOAD;
    endcase
  end

  always_comb begin
    busy      = (state_r != S_LOAD);
    res_valid = (state_r == S_OUT);
    res_row   = i_r;
    res_col   = rasg_v_r[i_r] ? rasg_r[i_r] : '0;
    res_last  = last_i;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_LOAD: begin
        n_r <= n_in;
        i_r <= '0; j_r <= '0; k_r <= '0;
      end
      S_INIT: begin
        for (int x = 0; x < MAX_SIZE; x++) begin
          rdual_r[x] <= '0; cdual_r[x] <= '0; pred_r[x] <= '0;
        end
        cown_v_r <= '0; rasg_v_r <= '0;
        i_r <= '0; j_r <= '0;
      end
      S_RMIN_CMP, S_CMIN_CMP: begin
        if (j_r == '0 || red < acc_r) acc_r <= red;
        j_r <= last_j ? '0 : j_r + IDX_W'(1);
      end
      S_RMIN_WR: begin
        rdual_r[i_r] <= acc_r;
        i_r <= last_i ? '0 : i_r + IDX_W'(1);
      end
      S_CMIN_WR: begin
        cdual_r[i_r] <= acc_r;
        i_r <= last_i ? '0 : i_r + IDX_W'(1);
      end
      S_GRD_CMP: begin
        if (red == 0 && !cown_v_r[j_r]) begin
          cown_v_r[j_r] <= 1'b1; cown_r[j_r] <= i_r;
          rasg_v_r[i_r] <= 1'b1; rasg_r[i_r] <= j_r;
        end
        if (state_nxt == S_ROW_NEXT) begin
          j_r <= '0; k_r <= '0; i_r <= '0;
        end else if ((red == 0 && !cown_v_r[j_r]) || last_j) begin
          j_r <= '0; i_r <= i_r + IDX_W'(1);
        end else begin
          j_r <= j_r + IDX_W'(1);
        end
      end
      S_ROW_NEXT: begin
        if (k_r < n_r && rasg_v_r[k_r[IDX_W-1:0]]) k_r <= k_r + SZ_W'(1);
        if (k_r >= n_r) i_r <= '0;
      end
      S_TREE_INIT: begin
        for (int x = 0; x < MAX_SIZE; x++) slack_r[x] <= SLACK_MAX;
        lab_r <= '0; scol_r <= '0; srow_r <= '0;
        r_r <= k_r[IDX_W-1:0]; j_r <= '0; guard_r <= '0;
      end
      S_SCAN_CMP: begin
        srow_r[r_r] <= 1'b1;
        if (!lab_r[j_r] && red < slack_r[j_r]) begin
          pred_r[j_r]  <= r_r;
          slack_r[j_r] <= red;
          if (red == 0) lab_r[j_r] <= 1'b1;
        end
        j_r <= last_j ? '0 : j_r + IDX_W'(1);
        acc_r <= SLACK_MAX;
      end
      S_DELTA: begin
        if (!lab_r[j_r] && slack_r[j_r] < acc_r) acc_r <= slack_r[j_r];
        j_r <= last_j ? '0 : j_r + IDX_W'(1);
      end
      S_DUALS: begin
        for (int x = 0; x < MAX_SIZE; x++) begin
          if (x < n_r) begin
            if (srow_r[x]) rdual_r[x] <= rdual_r[x] + acc_r;
            if (lab_r[x])  cdual_r[x] <= cdual_r[x] - acc_r;
            if (!lab_r[x]) begin
              slack_r[x] <= slack_r[x] - acc_r;
              if (slack_r[x] == acc_r) lab_r[x] <= 1'b1;
            end
          end
        end
      end
      S_SLK: begin
        if (pend == '0) k_r <= k_r + SZ_W'(1);
      end
      S_PICK: begin
        scol_r[pend_idx] <= 1'b1;
        if (!cown_v_r[pend_idx]) begin
          j_r <= pend_idx; guard_r <= '0;
        end else begin
          j_r <= '0;
          guard_r <= guard_r + SZ_W'(1);
          r_r <= cown_r[pend_idx];
          if (state_nxt == S_ROW_NEXT) k_r <= k_r + SZ_W'(1);
        end
      end
      S_AUG: begin
        cown_v_r[j_r] <= 1'b1; cown_r[j_r] <= pred_r[j_r];
        rasg_v_r[pred_r[j_r]] <= 1'b1; rasg_r[pred_r[j_r]] <= j_r;
        j_r <= rasg_r[pred_r[j_r]];
        guard_r <= guard_r + 1'b1;
        if (state_nxt == S_ROW_NEXT) k_r <= k_r + SZ_W'(1);
      end
      S_OUT: begin
        if (res_ready) i_r <= i_r + IDX_W'(1);
      end
      default: begin
      end
    endcase
  end
endmodule

// File: hdl/hungarian_assignment_solver.sv
// Top level of the assignment solver: stream ports, size register, cost RAM.
// Depends on has_pkg, has_ram and has_core.
//
// Use: write size_in_use (2..16) on cfg_ while idle; reset value 16.
// Load cost beats on in_ (one a cycle). A beat with in_tlast high stores
// its entry and starts the solve; in_tready stays low until all n result
// beats have left on out_. Each out_ beat carries one row and its column,
// rows in ascending order, with out_tlast on row n-1.
// Steps of a solve, in order: row reduction, column reduction, greedy
// matching, then for each unassigned row an augmenting tree of row scans
// (with a dual update when no labelled column is pending) and path flips.
// All steps read costs through the one read port of the cost RAM.
// Output is held while out_tready is low. Reset empties the sequencer and
// sets size to 16; the cost RAM is not cleared.
module hungarian_assignment_solver (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // row_index[3:0], column_index[7:4], cost[23:8]
  input  logic        in_tlast,   // last_entry
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // result_row[3:0], assigned_column[7:4]
  output logic        out_tlast,  // last_of_run
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [4:0]  cfg_data    // size_in_use
);
  import has_pkg::*;

  logic [SZ_W-1:0] size_r;
  logic [SZ_W-1:0] n_eff;
  logic busy, acc, start;
  logic [ADDR_W-1:0] raddr;
  logic [COST_WIDTH-1:0] rdata;
  logic [IDX_W-1:0] rrow, rcol;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= SZ_W'(MAX_SIZE);
    end else if (cfg_valid) begin
      size_r <= cfg_data;
    end
  end

  assign n_eff = (size_r < SZ_W'(2)) ? SZ_W'(2) :
                 (size_r > SZ_W'(MAX_SIZE)) ? SZ_W'(MAX_SIZE) : size_r;

  assign in_tready = !busy;
  assign acc   = in_tvalid && in_tready;
  assign start = acc && in_tlast;

  has_ram #(.WIDTH(COST_WIDTH), .DEPTH(MAX_SIZE * MAX_SIZE)) u_cost (
    .clk   (clk),
    .we    (acc),
    .waddr ({in_tdata[3:0], in_tdata[7:4]}),
    .wdata (in_tdata[23:8]),
    .raddr (raddr),
    .rdata (rdata)
  );

  has_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .n_in       (n_eff),
    .cost_raddr (raddr),
    .cost_rdata (rdata),
    .busy       (busy),
    .res_valid  (out_tvalid),
    .res_ready  (out_tready),
    .res_row    (rrow),
    .res_col    (rcol),
    .res_last   (out_tlast)
  );

  assign out_tdata = {rcol, rrow};
endmodule

// File: hdl/has_checker.sv
// Port-level checks for the assignment solver, bound to the top level.
// Depends on hungarian_assignment_solver port names only.
module has_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic       in_tlast,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast
);
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready) else $error("input taken during result");
  a_solve_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tlast) |=> !in_tready) else $error("no solve");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> out_tvalid && $stable(out_tdata))
    else $error("beat dropped");
  a_first_row: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> out_tdata[3:0] == 4'd0) else $error("bad first row");
  a_last_free: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tlast) |=> !out_tvalid) else $error("extra beat");
endmodule

bind hungarian_assignment_solver has_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .in_tlast(in_tlast), .out_tvalid(out_tvalid), .out_tready(out_tready),
  .out_tdata(out_tdata), .out_tlast(out_tlast)
);
